FILE: design/swrl_pkg.sv
package swrl_pkg;

   // Default sizing
   localparam int CLIENTS_DEF   = 64;
   localparam int LOG_DEPTH_DEF = 64;

   // Field widths
   localparam int ID_W       = 6;
   localparam int TIME_W     = 48;
   localparam int WINDOW_W   = 16;
   localparam int MAX_EV_W   = 7;
   localparam int BLOCK_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(1000);
   localparam logic [MAX_EV_W-1:0] MAX_EV_RST = MAX_EV_W'(50);
   localparam logic [BLOCK_W-1:0]  BLOCK_RST  = BLOCK_W'(60000);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NEW_BLOCK = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   client_id;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                allowed;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_POP_RD,
      ST_POP_CHK,
      ST_DECIDE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic                clear_step;
      logic                take;
      logic                lookup;
      logic                log_rd;
      logic                rd_next;
      logic                pop;
      logic                commit_block;
      logic                commit_log;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic in_range;
      logic blocked;
      logic lookup_empty;
      logic expired;
      logic count_one;
      logic at_limit;
      logic rsp_free;
   } sts_type;

endpackage

FILE: design/swrl_dp.sv
module swrl_dp #(
   parameter int CLIENTS   = swrl_pkg::CLIENTS_DEF,
   parameter int LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  swrl_pkg::req_type                   req_data,
   input  logic                                csr_valid,
   input  logic [swrl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [swrl_pkg::CSR_DATA_W-1:0]     csr_data,
   input  swrl_pkg::cmd_type                   cmd,
   output swrl_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output swrl_pkg::rsp_type                   rsp_data
);

   localparam int TW      = swrl_pkg::TIME_W;
   localparam int CID_W   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
   localparam int HEAD_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
   localparam int SUM_W   = HEAD_W + 1;
   localparam int LOG_N   = CLIENTS * LOG_DEPTH;
   localparam int LOG_AW  = (LOG_N > 1) ? $clog2(LOG_N) : 1;
   localparam int CE_W    = TW + HEAD_W + CNT_W;

   // Configuration registers
   logic [swrl_pkg::WINDOW_W-1:0] window_ff;
   logic [swrl_pkg::MAX_EV_W-1:0] max_ev_ff;
   logic [swrl_pkg::BLOCK_W-1:0]  block_ff;

   // Request context
   swrl_pkg::req_type req_ff;
   logic [CID_W-1:0]  cid_ff;
   logic [LOG_AW-1:0] base_ff;
   logic [TW-1:0]     end_ff;
   logic [TW:0]       end_sum;

   // Per-client store: block end, ring head, entry count
   logic [CE_W-1:0]   cli_mem [CLIENTS];
   logic [CE_W-1:0]   cli_rd_ff;
   logic [CID_W-1:0]  cli_wr_addr;
   logic [CE_W-1:0]   cli_wr_data;
   logic              cli_wr_en;
   logic [CID_W-1:0]  clr_idx_ff;

   // Timestamp log, one ring of LOG_DEPTH per client
   logic [TW-1:0]     log_mem [LOG_N];
   logic [TW-1:0]     log_rd_ff;
   logic [LOG_AW-1:0] log_rd_addr;
   logic [LOG_AW-1:0] log_wr_addr;

   // Working ring pointer
   logic [HEAD_W-1:0] head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [HEAD_W-1:0] head_next;
   logic [SUM_W-1:0]  slot_sum;
   logic [HEAD_W-1:0] wr_slot;

   logic [TW-1:0]     rd_end;
   logic [HEAD_W-1:0] rd_head;
   logic [CNT_W-1:0]  rd_count;
   logic              cleared;
   logic [TW:0]       age;
   logic [31:0]       limit;

   logic              rsp_valid_ff;
   swrl_pkg::rsp_type rsp_ff;
   logic              rsp_free;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= swrl_pkg::WINDOW_RST;
         max_ev_ff <= swrl_pkg::MAX_EV_RST;
         block_ff  <= swrl_pkg::BLOCK_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            swrl_pkg::CSR_WINDOW: window_ff <= csr_data[swrl_pkg::WINDOW_W-1:0];
            swrl_pkg::CSR_MAX_EV: max_ev_ff <= csr_data[swrl_pkg::MAX_EV_W-1:0];
            swrl_pkg::CSR_BLOCK:  block_ff  <= csr_data[swrl_pkg::BLOCK_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request beat and look up its client
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_ff    <= req_data;
         cid_ff    <= CID_W'(req_data.client_id);
         base_ff   <= LOG_AW'(32'(CID_W'(req_data.client_id)) * LOG_DEPTH);
         cli_rd_ff <= cli_mem[CID_W'(req_data.client_id)];
      end
   end

   // Saturating block end, refreshed every cycle from the held timestamp
   assign end_sum = {1'b0, req_ff.now_ms} + (TW + 1)'(block_ff);

   always_ff @(posedge clock) begin
      end_ff <= end_sum[TW] ? {TW{1'b1}} : end_sum[TW-1:0];
   end

   // Unpack the client entry
   assign rd_end   = cli_rd_ff[CE_W-1 -: TW];
   assign rd_head  = cli_rd_ff[CNT_W +: HEAD_W];
   assign rd_count = cli_rd_ff[CNT_W-1:0];
   assign cleared  = (rd_end != '0);

   // Ring arithmetic
   always_comb begin
      if (32'(head_ff) == LOG_DEPTH - 1) begin
         head_next = '0;
      end else begin
         head_next = head_ff + HEAD_W'(1);
      end
      slot_sum = {1'b0, head_ff} + SUM_W'(count_ff);
      if (32'(slot_sum) >= LOG_DEPTH) begin
         wr_slot = HEAD_W'(slot_sum - SUM_W'(LOG_DEPTH));
      end else begin
         wr_slot = HEAD_W'(slot_sum);
      end
   end

   // Load, advance and hold the working pointer
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         head_ff  <= cleared ? '0 : rd_head;
         count_ff <= cleared ? '0 : rd_count;
      end else if (cmd.pop) begin
         head_ff  <= head_next;
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Clearing pass index
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_idx_ff <= clr_idx_ff + CID_W'(1);
      end
   end

   // Client store write port
   always_comb begin
      cli_wr_en   = cmd.clear_step || cmd.commit_block || cmd.commit_log;
      cli_wr_addr = cmd.clear_step ? clr_idx_ff : cid_ff;
      if (cmd.clear_step) begin
         cli_wr_data = '0;
      end else if (cmd.commit_block) begin
         cli_wr_data = {end_ff, head_ff, count_ff};
      end else begin
         cli_wr_data = {{TW{1'b0}}, head_ff, count_ff + CNT_W'(1)};
      end
   end

   always_ff @(posedge clock) begin
      if (cli_wr_en) begin
         cli_mem[cli_wr_addr] <= cli_wr_data;
      end
   end

   // Timestamp log ports
   assign log_rd_addr = base_ff + LOG_AW'(cmd.rd_next ? head_next : head_ff);
   assign log_wr_addr = base_ff + LOG_AW'(wr_slot);

   always_ff @(posedge clock) begin
      if (cmd.commit_log) begin
         log_mem[log_wr_addr] <= req_ff.now_ms;
      end
      if (cmd.log_rd) begin
         log_rd_ff <= log_mem[log_rd_addr];
      end
   end

   // Age of the oldest entry; a future timestamp never expires
   assign age   = {1'b0, req_ff.now_ms} - {1'b0, log_rd_ff};
   assign limit = (32'(max_ev_ff) > LOG_DEPTH) ? 32'(LOG_DEPTH) : 32'(max_ev_ff);

   // Result register
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.allowed <= (cmd.rsp_status == swrl_pkg::STATUS_ACCEPT);
         rsp_ff.status  <= cmd.rsp_status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the controller
   always_comb begin
      sts.clear_last   = (32'(clr_idx_ff) == CLIENTS - 1);
      sts.in_range     = (32'(req_ff.client_id) < CLIENTS);
      sts.blocked      = (rd_end > req_ff.now_ms);
      sts.lookup_empty = cleared || (rd_count == '0);
      sts.expired      = !age[TW] &&
                         ((age[TW-1:swrl_pkg::WINDOW_W] != '0) ||
                          (age[swrl_pkg::WINDOW_W-1:0] > window_ff));
      sts.count_one    = (count_ff == CNT_W'(1));
      sts.at_limit     = (32'(count_ff) >= limit);
      sts.rsp_free     = rsp_free;
   end

   a_log_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_log |-> (32'(count_ff) < LOG_DEPTH))
      else $error("log written while full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (count_ff != '0))
      else $error("pop from empty log");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> rsp_free)
      else $error("result overwritten before delivery");

endmodule

FILE: design/swrl_ctrl.sv
module swrl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  swrl_pkg::sts_type sts,
   output swrl_pkg::cmd_type cmd
);

   swrl_pkg::state_type state_ff;
   swrl_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swrl_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.rsp_status = swrl_pkg::STATUS_ACCEPT;
      unique case (state_ff)
         swrl_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = swrl_pkg::ST_IDLE;
            end
         end
         swrl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = swrl_pkg::ST_LOOKUP;
            end
         end
         swrl_pkg::ST_LOOKUP: begin
            // Refuse bad slots and clients still blocked; else drop expired entries
            if (!sts.in_range || sts.blocked) begin
               if (sts.rsp_free) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = swrl_pkg::STATUS_BLOCKED;
                  state_in       = swrl_pkg::ST_IDLE;
               end
            end else begin
               cmd.lookup = 1'b1;
               state_in   = sts.lookup_empty ? swrl_pkg::ST_DECIDE : swrl_pkg::ST_POP_RD;
            end
         end
         swrl_pkg::ST_POP_RD: begin
            cmd.log_rd = 1'b1;
            state_in   = swrl_pkg::ST_POP_CHK;
         end
         swrl_pkg::ST_POP_CHK: begin
            // Fetch the following entry while the current one is judged
            if (sts.expired) begin
               cmd.pop     = 1'b1;
               cmd.log_rd  = 1'b1;
               cmd.rd_next = 1'b1;
               if (sts.count_one) begin
                  state_in = swrl_pkg::ST_DECIDE;
               end
            end else begin
               state_in = swrl_pkg::ST_DECIDE;
            end
         end
         swrl_pkg::ST_DECIDE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = swrl_pkg::ST_IDLE;
               if (sts.at_limit) begin
                  cmd.commit_block = 1'b1;
                  cmd.rsp_status   = swrl_pkg::STATUS_NEW_BLOCK;
               end else begin
                  cmd.commit_log = 1'b1;
                  cmd.rsp_status = swrl_pkg::STATUS_ACCEPT;
               end
            end
         end
         default: begin
            state_in = swrl_pkg::ST_CLEAR;
         end
      endcase
   end

   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swrl_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_one_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit_block && cmd.commit_log))
      else $error("block and log commit together");

   a_commit_then_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_block || cmd.commit_log) |=> (state_ff == swrl_pkg::ST_IDLE))
      else $error("commit did not finish the request");

endmodule

FILE: design/sliding_window_rate_limiter.sv
// Channel   Direction  Handshake              Beat
// req_      in         req_valid/req_ready    req_data: client_id, now_ms
// rsp_      out        rsp_valid/rsp_ready    rsp_data: allowed, status
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// A request is taken in IDLE; LOOKUP refuses it, or an empty client log goes to DECIDE,
// else POP_RD and POP_CHK drop expired timestamps oldest first before DECIDE; the log
// memory gives one read per cycle and sets the drop rate.
// After reset a clearing pass zeroes the client store; req_ready stays low meanwhile,
// register writes are taken at all times.
// A waiting result does not block the next request; the block stalls only when a
// second result is finished before the first is taken.
module sliding_window_rate_limiter #(
   parameter int CLIENTS   = swrl_pkg::CLIENTS_DEF,
   parameter int LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  swrl_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output swrl_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [swrl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swrl_pkg::CSR_DATA_W-1:0] csr_data
);

   swrl_pkg::cmd_type cmd;
   swrl_pkg::sts_type sts;

   // Register writes are always accepted and registered directly
   assign csr_ready = 1'b1;

   swrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   swrl_dp #(
      .CLIENTS   (CLIENTS),
      .LOG_DEPTH (LOG_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = swrl_pkg::CLIENTS_DEF;
   localparam int DEPTH       = swrl_pkg::LOG_DEPTH_DEF;
   localparam int HEAD_W      = $clog2(DEPTH);
   localparam int PERIOD      = 8;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 108;
   localparam int CALM_ITEMS  = 100;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 200;
   localparam int PRINT_CAP   = 100;

   localparam logic [swrl_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [swrl_pkg::TIME_W-1:0]    TIME_MAX   = {swrl_pkg::TIME_W{1'b1}};

   localparam swrl_pkg::rsp_type RSP_OK   =
      '{allowed: 1'b1, status: swrl_pkg::STATUS_ACCEPT};
   localparam swrl_pkg::rsp_type RSP_HELD =
      '{allowed: 1'b0, status: swrl_pkg::STATUS_BLOCKED};
   localparam swrl_pkg::rsp_type RSP_TRIP =
      '{allowed: 1'b0, status: swrl_pkg::STATUS_NEW_BLOCK};

   typedef struct packed {
      logic                            is_csr;
      logic [swrl_pkg::CSR_IDX_W-1:0]  idx;
      logic [swrl_pkg::CSR_DATA_W-1:0] value;
      swrl_pkg::req_type               item;
      logic                            pinned;
      swrl_pkg::rsp_type               want;
   } plan_row_type;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   swrl_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   swrl_pkg::rsp_type               rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [swrl_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [swrl_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   // Expected verdict pinned by hand for a directed beat
   logic              pin_on  = 1'b0;
   swrl_pkg::rsp_type pin_rsp = '0;

   bit calm     = 1'b0;
   bit hold_req = 1'b0;

   // Limiter shadow: registers and per-client stores
   logic [swrl_pkg::WINDOW_W-1:0] cfg_window;
   logic [swrl_pkg::MAX_EV_W-1:0] cfg_max_ev;
   logic [swrl_pkg::BLOCK_W-1:0]  cfg_block;
   logic [swrl_pkg::TIME_W-1:0]   blocked_until [SLOTS];
   logic [swrl_pkg::TIME_W-1:0]   stamp_ring [SLOTS][DEPTH];
   logic [HEAD_W-1:0]             stamp_head [SLOTS];
   logic [HEAD_W:0]               stamp_fill [SLOTS];

   swrl_pkg::rsp_type verdict_q[$];
   plan_row_type      plan_q[$];

   int error_count = 0;
   int stall_cycles = 0;
   int req_beats = 0;
   int csr_beats = 0;
   int allowed_n = 0;
   int held_n = 0;
   int tripped_n = 0;

   sliding_window_rate_limiter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic void limiter_clear();
      cfg_window = swrl_pkg::WINDOW_RST;
      cfg_max_ev = swrl_pkg::MAX_EV_RST;
      cfg_block  = swrl_pkg::BLOCK_RST;
      for (int c = 0; c < SLOTS; c++) begin
         blocked_until[c] = '0;
         stamp_head[c]    = '0;
         stamp_fill[c]    = '0;
         for (int e = 0; e < DEPTH; e++) begin
            stamp_ring[c][e] = '0;
         end
      end
   endfunction

   function automatic void apply_register(input logic [swrl_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [swrl_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         swrl_pkg::CSR_WINDOW: cfg_window = value[swrl_pkg::WINDOW_W-1:0];
         swrl_pkg::CSR_MAX_EV: cfg_max_ev = value[swrl_pkg::MAX_EV_W-1:0];
         swrl_pkg::CSR_BLOCK:  cfg_block  = value[swrl_pkg::BLOCK_W-1:0];
         default: ;
      endcase
   endfunction

   // Decide one request and update the client's block and timestamp log
   function automatic swrl_pkg::rsp_type limiter_decide(input swrl_pkg::req_type item);
      int unsigned                 cid;
      int unsigned                 cap;
      logic [swrl_pkg::TIME_W-1:0] now_v;
      logic [swrl_pkg::TIME_W-1:0] oldest;
      logic [swrl_pkg::TIME_W:0]   until_v;
      logic                        scanning;
      swrl_pkg::rsp_type           res;
      cid   = item.client_id;
      now_v = item.now_ms;
      res   = RSP_OK;
      if (blocked_until[cid] > now_v) begin
         res = RSP_HELD;
      end else begin
         // lift an ended block together with the log
         if (blocked_until[cid] != '0) begin
            blocked_until[cid] = '0;
            stamp_head[cid]    = '0;
            stamp_fill[cid]    = '0;
         end
         // drop stamps older than the window, oldest first; future stamps stay
         scanning = 1'b1;
         while (scanning && stamp_fill[cid] != '0) begin
            oldest = stamp_ring[cid][stamp_head[cid]];
            if (now_v >= oldest &&
                (now_v - oldest) > swrl_pkg::TIME_W'(cfg_window)) begin
               stamp_head[cid] = stamp_head[cid] + 1'b1;
               stamp_fill[cid] = stamp_fill[cid] - 1'b1;
            end else begin
               scanning = 1'b0;
            end
         end
         cap = (cfg_max_ev > DEPTH) ? DEPTH : cfg_max_ev;
         if (stamp_fill[cid] >= cap) begin
            // block, saturating the end time
            until_v = {1'b0, now_v};
            until_v = until_v + cfg_block;
            blocked_until[cid] = until_v[swrl_pkg::TIME_W] ? TIME_MAX :
                                 until_v[swrl_pkg::TIME_W-1:0];
            res = RSP_TRIP;
         end else begin
            stamp_ring[cid][HEAD_W'(stamp_head[cid] + stamp_fill[cid])] = now_v;
            stamp_fill[cid] = stamp_fill[cid] + 1'b1;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endtask

   // Sample beats, check results and watch for a hang
   always @(posedge clock) begin : observe
      swrl_pkg::rsp_type want;
      swrl_pkg::rsp_type decided;
      if (reset) begin
         limiter_clear();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.status == swrl_pkg::STATUS_ACCEPT) begin
               allowed_n++;
            end else if (rsp_data.status == swrl_pkg::STATUS_BLOCKED) begin
               held_n++;
            end else begin
               tripped_n++;
            end
            if (verdict_q.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.allowed !== want.allowed) begin
                  report_mismatch($sformatf("allowed got %b want %b",
                                            rsp_data.allowed, want.allowed));
               end
               if (rsp_data.status !== want.status) begin
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_data.status, want.status));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            csr_beats++;
            apply_register(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            req_beats++;
            decided = limiter_decide(req_data);
            verdict_q.push_back(pin_on ? pin_rsp : decided);
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, verdict_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Result side: random ready bursts, one long hold-off on request
   initial begin : result_side
      int span;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            span = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (span - 1) @(negedge clock);
         end else begin
            span = $urandom_range(1, 12);
            rsp_ready <= 1'b1;
            repeat (span - 1) @(negedge clock);
         end
      end
   end

   task automatic drive_request(input swrl_pkg::req_type item, input logic pinned,
                                input swrl_pkg::rsp_type pinned_rsp);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      pin_on    <= pinned;
      pin_rsp   <= pinned_rsp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(input logic [swrl_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [swrl_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering and hold until every result is back
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(negedge clock);
   endtask

   function automatic void plan_req(input logic [swrl_pkg::ID_W-1:0] cid,
                                    input logic [swrl_pkg::TIME_W-1:0] at);
      plan_row_type row;
      row = '0;
      row.item.client_id = cid;
      row.item.now_ms    = at;
      plan_q.push_back(row);
   endfunction

   function automatic void plan_known(input logic [swrl_pkg::ID_W-1:0] cid,
                                      input logic [swrl_pkg::TIME_W-1:0] at,
                                      input swrl_pkg::rsp_type want);
      plan_row_type row;
      row = '0;
      row.item.client_id = cid;
      row.item.now_ms    = at;
      row.pinned         = 1'b1;
      row.want           = want;
      plan_q.push_back(row);
   endfunction

   function automatic void plan_csr(input logic [swrl_pkg::CSR_IDX_W-1:0] idx,
                                    input logic [swrl_pkg::CSR_DATA_W-1:0] value);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.value  = value;
      plan_q.push_back(row);
   endfunction

   initial begin : stimulus
      swrl_pkg::req_type            item;
      logic [swrl_pkg::TIME_W-1:0]  wall_ms;
      logic [swrl_pkg::BLOCK_W-1:0] blk;
      int win;
      int lim;
      int step_max;
      int base;
      int span;
      int roll;
      int which;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: fresh client, limit trip and hold, saturated block end,
      // stale time, zero limit, zero block, unused register, wide settings
      plan_known(6'd0, 48'd0, RSP_OK);
      plan_csr(CSR_UNUSED, 32'hA5C3_5A3C);
      plan_csr(swrl_pkg::CSR_MAX_EV, 32'hFFFF_FF82);
      plan_csr(swrl_pkg::CSR_BLOCK, 32'd10);
      plan_csr(swrl_pkg::CSR_WINDOW, 32'hFFFF_0001);
      plan_known(6'd1, 48'd100, RSP_OK);
      plan_req(6'd1, 48'd101);
      plan_known(6'd1, 48'd101, RSP_TRIP);
      plan_known(6'd1, 48'd105, RSP_HELD);
      plan_req(6'd1, 48'd111);
      plan_known(6'd63, TIME_MAX, RSP_OK);
      plan_req(6'd63, TIME_MAX);
      plan_known(6'd63, TIME_MAX, RSP_TRIP);
      plan_req(6'd63, TIME_MAX);
      plan_req(6'd2, 48'd500);
      plan_req(6'd2, 48'd10);
      plan_req(6'd2, 48'd20);
      plan_csr(swrl_pkg::CSR_MAX_EV, 32'd0);
      plan_known(6'd4, 48'd50, RSP_TRIP);
      plan_csr(swrl_pkg::CSR_BLOCK, 32'd0);
      plan_req(6'd5, 48'd70);
      plan_req(6'd5, 48'd70);
      plan_csr(swrl_pkg::CSR_MAX_EV, 32'd127);
      plan_csr(swrl_pkg::CSR_WINDOW, 32'd65535);
      plan_csr(swrl_pkg::CSR_BLOCK, 32'hFFFF_FFFF);
      plan_known(6'd3, 48'd0, RSP_OK);
      plan_req(6'd0, 48'd5000);

      foreach (plan_q[r]) begin
         if (plan_q[r].is_csr) begin
            wait_quiet();
            write_register(plan_q[r].idx, plan_q[r].value);
         end else begin
            drive_request(plan_q[r].item, plan_q[r].pinned, plan_q[r].want);
         end
      end

      // Random phases: new settings, a small group of busy clients, some noise
      wall_ms = 48'd10000;
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_quiet();
         case ($urandom_range(0, 5))
            0: win = 1;
            1: win = 65535;
            default: win = $urandom_range(10, 400);
         endcase
         case ($urandom_range(0, 7))
            0: lim = 1;
            1: lim = DEPTH;
            2: lim = $urandom_range(DEPTH + 1, 127);
            3: lim = 0;
            default: lim = $urandom_range(2, 10);
         endcase
         case ($urandom_range(0, 9))
            0: blk = '0;
            1: blk = $urandom;
            2: blk = 32'd1;
            default: blk = $urandom_range(5, 600);
         endcase
         which = (ph == 0) ? 7 : $urandom_range(1, 7);
         if (which[0]) write_register(swrl_pkg::CSR_WINDOW, {16'($urandom), 16'(win)});
         if (which[1]) write_register(swrl_pkg::CSR_MAX_EV, {25'($urandom), 7'(lim)});
         if (which[2]) write_register(swrl_pkg::CSR_BLOCK, blk);
         if (!which[0]) win = 400;
         step_max = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : win / 8 + 1;
         base = $urandom_range(0, SLOTS - 1);
         span = $urandom_range(1, 6);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == PHASES - 1 && k == PHASE_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (ph == 3 && k == 40) hold_req = 1'b1;
            if (ph == 5 && k == 50) wait_quiet();
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               // any slot at any time
               item.client_id = swrl_pkg::ID_W'($urandom);
               item.now_ms    = swrl_pkg::TIME_W'({$urandom, $urandom});
            end else if (roll < 10) begin
               // time behind the busy clients
               item.client_id = swrl_pkg::ID_W'(base + $urandom_range(0, span - 1));
               item.now_ms    = wall_ms - $urandom_range(0, 2000);
            end else begin
               wall_ms = wall_ms + $urandom_range(0, step_max);
               item.client_id = swrl_pkg::ID_W'(base + $urandom_range(0, span - 1));
               item.now_ms    = wall_ms;
            end
            drive_request(item, 1'b0, RSP_OK);
         end
      end

      wait_quiet();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Run covered %0d requests and %0d register writes over %0d phases",
               req_beats, csr_beats, PHASES);
      $display("Results: %0d allowed, %0d refused while blocked, %0d newly blocked",
               allowed_n, held_n, tripped_n);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/swrl_pkg.sv
design/swrl_dp.sv
design/swrl_ctrl.sv
design/sliding_window_rate_limiter.sv
tb/sv/tb_top.sv
